// ===== rtl/qkb_pkg.sv =====
// Shared constants, types and the quadrature table for the knob decoder.
package qkb_pkg;

  localparam int EV_W = 3;
  localparam int DEB_W = 8;
  localparam int HOLD_W = 16;
  localparam int CFG_W = 16;

  localparam logic [EV_W-1:0] EV_NONE  = 3'd0;
  localparam logic [EV_W-1:0] EV_CW    = 3'd1;
  localparam logic [EV_W-1:0] EV_CCW   = 3'd2;
  localparam logic [EV_W-1:0] EV_SHORT = 3'd3;
  localparam logic [EV_W-1:0] EV_LONG  = 3'd4;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_LOAD = 1'b1;

  localparam logic CFG_DEBOUNCE = 1'b0;
  localparam logic CFG_LONG     = 1'b1;

  localparam logic [DEB_W-1:0]  DEB_RESET  = 8'd20;
  localparam logic [HOLD_W-1:0] LONG_RESET = 16'd1500;
  localparam logic [HOLD_W-1:0] HOLD_MAX   = 16'hFFFF;

  localparam logic [1:0] AB_RESET = 2'b11;

  // Quarter step from {previous AB, current AB}
  localparam logic signed [1:0] QUAD_TAB [16] = '{
    2'sd0,  -2'sd1, 2'sd1,  2'sd0,
    2'sd1,  2'sd0,  2'sd0,  -2'sd1,
    -2'sd1, 2'sd0,  2'sd0,  2'sd1,
    2'sd0,  2'sd1,  -2'sd1, 2'sd0
  };

  typedef struct packed {
    logic cw;
    logic ccw;
  } rot_ev_t;

  typedef struct packed {
    logic short_press;
    logic long_press;
  } btn_ev_t;

endpackage

// ===== rtl/qkb_rot.sv =====
// Quadrature decode and quarter-step accumulator.
module qkb_rot (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             load,
  input  logic             pin_a,
  input  logic             pin_b,
  output qkb_pkg::rot_ev_t rot_ev
);

  logic [1:0]        last_ab_r, last_ab_nxt;
  logic signed [2:0] accum_r, accum_nxt;
  logic [1:0]        ab;
  logic signed [1:0] qstep;
  logic signed [3:0] sum;

  always_comb begin
    ab        = {pin_a, pin_b};
    qstep     = qkb_pkg::QUAD_TAB[{last_ab_r, ab}];
    sum       = {accum_r[2], accum_r} + {{2{qstep[1]}}, qstep};
    rot_ev    = '0;
    last_ab_nxt = ab;
    accum_nxt = sum[2:0];
    if (load) begin
      accum_nxt = '0;
    end else if (sum >= 4'sd4) begin
      accum_nxt = '0;
      rot_ev.cw = 1'b1;
    end else if (sum <= -4'sd4) begin
      accum_nxt = '0;
      rot_ev.ccw = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_ab_r <= qkb_pkg::AB_RESET;
      accum_r   <= '0;
    end else if (adv) begin
      last_ab_r <= last_ab_nxt;
      accum_r   <= accum_nxt;
    end
  end

endmodule

// ===== rtl/qkb_btn.sv =====
// Switch debounce with short and long press detection.
module qkb_btn (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       load,
  input  logic                       switch_level,
  input  logic [qkb_pkg::DEB_W-1:0]  deb_ticks,
  input  logic [qkb_pkg::HOLD_W-1:0] long_ticks,
  output qkb_pkg::btn_ev_t           btn_ev
);

  logic                       raw_r, raw_nxt;
  logic                       stable_r, stable_nxt;
  logic                       long_done_r, long_done_nxt;
  logic [qkb_pkg::DEB_W-1:0]  scount_r, scount_nxt;
  logic [qkb_pkg::HOLD_W-1:0] hold_r, hold_nxt;
  logic                       pressed;

  always_comb begin
    pressed       = ~switch_level;
    raw_nxt       = raw_r;
    stable_nxt    = stable_r;
    long_done_nxt = long_done_r;
    scount_nxt    = scount_r;
    hold_nxt      = hold_r;
    btn_ev        = '0;
    if (load) begin
      raw_nxt       = pressed;
      stable_nxt    = pressed;
      long_done_nxt = 1'b0;
      scount_nxt    = '0;
      hold_nxt      = '0;
    end else begin
      if (pressed != raw_r) begin
        raw_nxt    = pressed;
        scount_nxt = '0;
      end else if (scount_r < deb_ticks) begin
        scount_nxt = scount_r + 1'b1;
      end
      if (scount_nxt >= deb_ticks && pressed != stable_r) begin
        stable_nxt = pressed;
        if (pressed) begin
          hold_nxt      = '0;
          long_done_nxt = 1'b0;
        end else if (!long_done_r) begin
          btn_ev.short_press = 1'b1;
        end
      end
      // count hold time until the long press fires once
      if (stable_nxt && !long_done_nxt) begin
        if (hold_nxt != qkb_pkg::HOLD_MAX) begin
          hold_nxt = hold_nxt + 1'b1;
        end
        if (hold_nxt >= long_ticks) begin
          long_done_nxt     = 1'b1;
          btn_ev.long_press = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r       <= 1'b0;
      stable_r    <= 1'b0;
      long_done_r <= 1'b0;
      scount_r    <= '0;
      hold_r      <= '0;
    end else if (adv) begin
      raw_r       <= raw_nxt;
      stable_r    <= stable_nxt;
      long_done_r <= long_done_nxt;
      scount_r    <= scount_nxt;
      hold_r      <= hold_nxt;
    end
  end

endmodule

// ===== rtl/quadrature_knob_with_button.sv =====
// Rotary knob decoder top level: input register, decode, result register.
// An accepted word is held in the input register, then decoded into the result register.
// Throughput: one word per cycle; the result register and input register
// stall together only when the result is not taken.
// Reset (synchronous, rst_n low): pipeline empty, last AB = 3, all counters
// clear, debounce_ticks = 20, long_press_ticks = 1500.
module quadrature_knob_with_button (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_req_type,
  input  logic                      in_pin_a,
  input  logic                      in_pin_b,
  input  logic                      in_switch_level,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [qkb_pkg::EV_W-1:0]  out_event_res,
  input  logic                      cfg_we,
  input  logic                      cfg_idx,
  input  logic [qkb_pkg::CFG_W-1:0] cfg_wdata
);

  logic                       s1_valid_r;
  logic                       s1_req_r, s1_a_r, s1_b_r, s1_sw_r;
  logic                       out_valid_r;
  logic [qkb_pkg::EV_W-1:0]   ev_r, ev_nxt;
  logic [qkb_pkg::DEB_W-1:0]  deb_r;
  logic [qkb_pkg::HOLD_W-1:0] long_r;
  logic                       s1_go, s1_adv, s1_load;
  qkb_pkg::rot_ev_t           rot_ev;
  qkb_pkg::btn_ev_t           btn_ev;

  assign s1_go    = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && s1_go;
  assign in_ready = !s1_valid_r || s1_go;
  assign s1_load  = (s1_req_r == qkb_pkg::REQ_LOAD);

  assign out_valid     = out_valid_r;
  assign out_event_res = ev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_r  <= qkb_pkg::DEB_RESET;
      long_r <= qkb_pkg::LONG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        qkb_pkg::CFG_DEBOUNCE: deb_r  <= cfg_wdata[qkb_pkg::DEB_W-1:0];
        qkb_pkg::CFG_LONG:     long_r <= cfg_wdata[qkb_pkg::HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_req_r <= in_req_type;
      s1_a_r   <= in_pin_a;
      s1_b_r   <= in_pin_b;
      s1_sw_r  <= in_switch_level;
    end
  end

  qkb_rot u_rot (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (s1_adv),
    .load   (s1_load),
    .pin_a  (s1_a_r),
    .pin_b  (s1_b_r),
    .rot_ev (rot_ev)
  );

  qkb_btn u_btn (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (s1_adv),
    .load         (s1_load),
    .switch_level (s1_sw_r),
    .deb_ticks    (deb_r),
    .long_ticks   (long_r),
    .btn_ev       (btn_ev)
  );

  // button events win over rotation
  always_comb begin
    priority if (s1_load)            ev_nxt = qkb_pkg::EV_NONE;
    else if (btn_ev.long_press)      ev_nxt = qkb_pkg::EV_LONG;
    else if (btn_ev.short_press)     ev_nxt = qkb_pkg::EV_SHORT;
    else if (rot_ev.cw)              ev_nxt = qkb_pkg::EV_CW;
    else if (rot_ev.ccw)             ev_nxt = qkb_pkg::EV_CCW;
    else                             ev_nxt = qkb_pkg::EV_NONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      ev_r <= ev_nxt;
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_load_none: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_load) |=> (out_valid && out_event_res == qkb_pkg::EV_NONE))
    else $error("load word produced an event");

  a_btn_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(btn_ev.short_press && btn_ev.long_press))
    else $error("short and long press in one tick");

  a_ev_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_event_res <= qkb_pkg::EV_LONG))
    else $error("event code out of range");

endmodule

// ===== verif/quadrature_knob_with_button_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the rotary knob decoder with debounced push button.
module quadrature_knob_with_button_test;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic in_req_type;
  logic in_pin_a;
  logic in_pin_b;
  logic in_switch_level;
  logic out_valid;
  logic out_ready;
  logic [qkb_pkg::EV_W-1:0] out_event_res;
  logic cfg_we;
  logic cfg_idx;
  logic [qkb_pkg::CFG_W-1:0] cfg_wdata;

  quadrature_knob_with_button uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_req_type(in_req_type),
    .in_pin_a(in_pin_a),
    .in_pin_b(in_pin_b),
    .in_switch_level(in_switch_level),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_event_res(out_event_res),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predicted decoder state and settings
  logic [qkb_pkg::DEB_W-1:0] deb_limit;
  logic [qkb_pkg::HOLD_W-1:0] long_limit;
  logic [1:0] prev_ab;
  logic signed [2:0] quarter_sum;
  logic sw_raw;
  logic sw_stable;
  logic long_sent;
  logic [qkb_pkg::DEB_W-1:0] settle_count;
  logic [qkb_pkg::HOLD_W-1:0] press_count;

  logic [qkb_pkg::EV_W-1:0] pending_events [$];
  int error_count = 0;
  bit idle_en = 1'b0;
  int hold_off_cycles = 0;
  int enc_pos = 2;
  int enc_dir = 1;

  // Position of an AB pair along the clockwise sequence 00, 10, 11, 01
  function automatic int pos_of_ab(input logic [1:0] ab);
    case (ab)
      2'b00: return 0;
      2'b10: return 1;
      2'b11: return 2;
      default: return 3;
    endcase
  endfunction

  function automatic logic [1:0] ab_of_pos(input int p);
    case (p & 3)
      0: return 2'b00;
      1: return 2'b10;
      2: return 2'b11;
      default: return 2'b01;
    endcase
  endfunction

  task automatic reset_model();
    deb_limit = qkb_pkg::DEB_RESET;
    long_limit = qkb_pkg::LONG_RESET;
    prev_ab = qkb_pkg::AB_RESET;
    quarter_sum = '0;
    sw_raw = 1'b0;
    sw_stable = 1'b0;
    long_sent = 1'b0;
    settle_count = '0;
    press_count = '0;
  endtask

  function automatic logic [qkb_pkg::EV_W-1:0] predict_event(input logic req,
                                                              input logic [1:0] ab,
                                                              input logic sw);
    logic [qkb_pkg::EV_W-1:0] ev;
    logic pressed;
    int sum;
    int turn;
    ev = qkb_pkg::EV_NONE;
    pressed = ~sw;
    if (req == qkb_pkg::REQ_LOAD) begin
      prev_ab = ab;
      quarter_sum = '0;
      sw_raw = pressed;
      sw_stable = pressed;
      long_sent = 1'b0;
      settle_count = '0;
      press_count = '0;
      return qkb_pkg::EV_NONE;
    end
    // one position forward or back is a quarter step; a jump of two is ignored
    turn = (pos_of_ab(ab) - pos_of_ab(prev_ab)) & 3;
    sum = quarter_sum;
    if (turn == 1) sum++;
    else if (turn == 3) sum--;
    prev_ab = ab;
    if (sum >= 4) begin
      sum = 0;
      ev = qkb_pkg::EV_CW;
    end else if (sum <= -4) begin
      sum = 0;
      ev = qkb_pkg::EV_CCW;
    end
    quarter_sum = sum[2:0];

    if (pressed != sw_raw) begin
      sw_raw = pressed;
      settle_count = '0;
    end else if (settle_count < deb_limit) begin
      settle_count = settle_count + 1'b1;
    end
    if (settle_count >= deb_limit && pressed != sw_stable) begin
      sw_stable = pressed;
      if (pressed) begin
        press_count = '0;
        long_sent = 1'b0;
      end else if (!long_sent) begin
        ev = qkb_pkg::EV_SHORT;
      end
    end
    if (sw_stable && !long_sent) begin
      if (press_count != qkb_pkg::HOLD_MAX) press_count = press_count + 1'b1;
      if (press_count >= long_limit) begin
        long_sent = 1'b1;
        ev = qkb_pkg::EV_LONG;
      end
    end
    return ev;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(input string what, input logic [qkb_pkg::EV_W-1:0] got,
                                 input logic [qkb_pkg::EV_W-1:0] want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  // Offer one word; valid stays high after acceptance until the next word or a pause
  task automatic send_word(input logic req, input logic [1:0] ab, input logic sw);
    int gap;
    gap = idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_pin_a <= ab[1];
    in_pin_b <= ab[0];
    in_switch_level <= sw;
    do @(posedge clk); while (!in_ready);
    pending_events.push_back(predict_event(req, ab, sw));
  endtask

  // Turn the knob a little (mostly along enc_dir, sometimes an illegal jump) and sample
  task automatic send_tick(input logic sw);
    int r;
    r = $urandom_range(0, 19);
    if (r < 11) enc_pos += enc_dir;
    else if (r < 13) enc_pos -= enc_dir;
    else if (r == 13) enc_pos += 2;
    enc_pos = enc_pos & 3;
    send_word(qkb_pkg::REQ_TICK, ab_of_pos(enc_pos), sw);
  endtask

  task automatic send_load(input logic [1:0] ab, input logic sw);
    enc_pos = pos_of_ab(ab);
    send_word(qkb_pkg::REQ_LOAD, ab, sw);
  endtask

  // Drop valid and drain the pipeline
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [qkb_pkg::CFG_W-1:0] val);
    settle();
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == qkb_pkg::CFG_DEBOUNCE) deb_limit = val[qkb_pkg::DEB_W-1:0];
    else long_limit = val;
  endtask

  always @(posedge clk) begin : check_results
    logic [qkb_pkg::EV_W-1:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_events.size() == 0) begin
        report_mismatch("unexpected word", out_event_res, qkb_pkg::EV_NONE);
      end else begin
        want = pending_events.pop_front();
        if (out_event_res !== want) report_mismatch("event_res", out_event_res, want);
      end
    end
  end

  // Result side: random stalls, plus a long hold-off on request
  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    forever begin
      if (hold_off_cycles > 0) begin
        stall = hold_off_cycles;
        hold_off_cycles = 0;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        stall = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      end else begin
        stall = 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic test_rotation();
    idle_en = 1'b0;
    for (int i = 1; i <= 4; i++) send_word(qkb_pkg::REQ_TICK, ab_of_pos(2 + i), 1'b1);
    for (int i = 1; i <= 4; i++) send_word(qkb_pkg::REQ_TICK, ab_of_pos(2 - i), 1'b1);
    // both channels flip at once
    send_word(qkb_pkg::REQ_TICK, 2'b00, 1'b1);
    send_word(qkb_pkg::REQ_TICK, 2'b11, 1'b1);
    enc_pos = 2;
  endtask

  // Long press colliding with a clockwise step, release after it, then a short press
  task automatic test_button();
    logic [9:0] press_plan;
    press_plan = 10'b1100110000;
    write_reg(qkb_pkg::CFG_DEBOUNCE, 16'd1);
    write_reg(qkb_pkg::CFG_LONG, 16'd3);
    idle_en = 1'b1;
    for (int i = 0; i < 10; i++) begin
      enc_pos = (enc_pos + 1) & 3;
      send_word(qkb_pkg::REQ_TICK, ab_of_pos(enc_pos), press_plan[i]);
    end
  endtask

  task automatic test_zero_settings();
    write_reg(qkb_pkg::CFG_DEBOUNCE, 16'd0);
    write_reg(qkb_pkg::CFG_LONG, 16'd0);
    idle_en = 1'b0;
    send_word(qkb_pkg::REQ_TICK, ab_of_pos(enc_pos), 1'b0);
    send_word(qkb_pkg::REQ_TICK, ab_of_pos(enc_pos), 1'b1);
    send_load(2'b00, 1'b0);
    send_word(qkb_pkg::REQ_TICK, 2'b01, 1'b0);
    send_load(2'b11, 1'b1);
  endtask

  // Count runs up toward a large threshold, then the threshold drops below it
  task automatic test_lowered_debounce();
    write_reg(qkb_pkg::CFG_DEBOUNCE, 16'd255);
    write_reg(qkb_pkg::CFG_LONG, qkb_pkg::LONG_RESET);
    repeat (6) send_tick(1'b0);
    write_reg(qkb_pkg::CFG_DEBOUNCE, 16'd2);
    send_tick(1'b0);
    repeat (3) send_tick(1'b1);
  endtask

  task automatic test_backpressure();
    settle();
    idle_en = 1'b0;
    hold_off_cycles = 60;
    while (out_ready) @(posedge clk);
    repeat (24) send_tick(1'($urandom_range(0, 1)));
  endtask

  // Slowest debounce with the longest hold: accept a press without a long press, then release
  task automatic test_extreme_settings();
    write_reg(qkb_pkg::CFG_DEBOUNCE, 16'd255);
    write_reg(qkb_pkg::CFG_LONG, qkb_pkg::HOLD_MAX);
    idle_en = 1'b0;
    send_load(ab_of_pos(enc_pos), 1'b1);
    repeat (258) send_tick(1'b0);
    repeat (258) send_tick(1'b1);
  endtask

  task automatic test_random();
    int deb_set [6] = '{1, 3, 6, 2, 12, 1};
    int long_set [6] = '{1, 8, 25, 40, 20, 12};
    logic sw_target;
    logic level;
    int sw_left;
    for (int p = 0; p < 6; p++) begin
      write_reg(qkb_pkg::CFG_DEBOUNCE, 16'(deb_set[p]));
      write_reg(qkb_pkg::CFG_LONG, 16'(long_set[p]));
      sw_target = 1'b1;
      sw_left = 0;
      for (int i = 0; i < 60; i++) begin
        if (i % 30 == 0) begin
          idle_en = ($urandom_range(0, 3) != 0);
          enc_dir = $urandom_range(0, 1) ? 1 : -1;
        end
        // alternate press and release runs, some too short to pass the debounce
        if (sw_left == 0) begin
          sw_target = ~sw_target;
          sw_left = $urandom_range(0, 1) ? $urandom_range(1, deb_set[p] + 3)
                                         : $urandom_range(deb_set[p] + 1,
                                                          deb_set[p] + long_set[p] + 8);
        end
        sw_left--;
        level = sw_target ^ ($urandom_range(0, 11) == 0);
        if ($urandom_range(0, 39) == 0) send_load(ab_of_pos($urandom_range(0, 3)), level);
        else send_tick(level);
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = qkb_pkg::REQ_TICK;
    in_pin_a = 1'b1;
    in_pin_b = 1'b1;
    in_switch_level = 1'b1;
    cfg_we = 1'b0;
    cfg_idx = qkb_pkg::CFG_DEBOUNCE;
    cfg_wdata = '0;
    reset_model();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_rotation();
    test_button();
    test_zero_settings();
    test_lowered_debounce();
    test_backpressure();
    test_extreme_settings();
    test_random();

    settle();
    repeat (6) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
